FILE: hdl/buq_pkg.sv
package buq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [7:0] BACKSPACE_BYTE = 8'h08;
  localparam logic [7:0] SPACE_BYTE     = 8'h20;

  typedef enum logic [1:0] {
    ACT_PUT  = 2'd0,
    ACT_GET  = 2'd1,
    ACT_LINE = 2'd2,
    ACT_RECV = 2'd3
  } act_t;

  // Source of the byte written to the transmit store.
  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_BS,
    SEL_SPACE
  } tsel_t;

  typedef struct packed {
    logic  load;
    logic  tx_push;
    tsel_t tx_sel;
    logic  tx_pop;
    logic  rx_push;
    logic  rx_pop;
    logic  result;
    logic  accepted;
  } cmd_t;

  typedef struct packed {
    act_t action;
    logic is_bs;
    logic tx_empty;
    logic tx_room1;
    logic tx_room4;
    logic rx_empty;
    logic rx_full;
  } stat_t;

endpackage

FILE: hdl/buq_in_if.sv
interface buq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data;

  modport source (output valid, output action, output data, input ready);
  modport sink   (input valid, input action, input data, output ready);
endinterface

FILE: hdl/buq_out_if.sv
interface buq_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       line_valid;
  logic [7:0] line_byte;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       tx_irq_enable;
  logic       rx_irq_enable;
  logic [3:0] tx_count;
  logic [3:0] rx_count;

  modport source (output valid, output accepted, output line_valid, output line_byte,
                  output read_valid, output read_byte, output tx_irq_enable,
                  output rx_irq_enable, output tx_count, output rx_count, input ready);
  modport sink   (input valid, input accepted, input line_valid, input line_byte,
                  input read_valid, input read_byte, input tx_irq_enable,
                  input rx_irq_enable, input tx_count, input rx_count, output ready);
endinterface

FILE: hdl/buq_dp.sv
module buq_dp import buq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] in_action,
  input  logic [7:0] in_data,
  input  cmd_t       cmd,
  output stat_t      stat,
  output logic       out_accepted,
  output logic       out_line_valid,
  output logic [7:0] out_line_byte,
  output logic       out_read_valid,
  output logic [7:0] out_read_byte,
  output logic       out_tx_irq_enable,
  output logic       out_rx_irq_enable,
  output logic [3:0] out_tx_count,
  output logic [3:0] out_rx_count
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = (PW > 4) ? PW : 4;
  localparam logic [PW-1:0] LAST  = PW'(QUEUE_DEPTH - 1);
  localparam logic [PW-1:0] ROOM4 = PW'(QUEUE_DEPTH - 5);

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == LAST) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_count(input logic [PW-1:0] w,
                                               input logic [PW-1:0] r);
    logic [PW:0] diff;
    diff = {1'b0, w} - {1'b0, r};
    if (w < r) begin
      diff = diff + (PW+1)'(QUEUE_DEPTH);
    end
    ring_count = diff[PW-1:0];
  endfunction

  logic [7:0] tx_mem [QUEUE_DEPTH];
  logic [7:0] rx_mem [QUEUE_DEPTH];
  logic [7:0] tx_rd_r, rx_rd_r;

  logic [PW-1:0] tx_w_r, tx_r_r, rx_w_r, rx_r_r;
  logic [PW-1:0] tx_w_nxt, tx_r_nxt, rx_w_nxt, rx_r_nxt;
  logic          tx_irq_r, rx_irq_r, tx_irq_nxt, rx_irq_nxt;
  act_t          act_r;
  logic [7:0]    data_r;
  logic [7:0]    tx_wr_byte;
  logic [PW-1:0] tx_cnt, rx_cnt, tx_cnt_nxt, rx_cnt_nxt;
  logic [CW-1:0] tx_cnt_ext, rx_cnt_ext;

  logic       acc_r, lv_r, rv_r;
  logic [7:0] lb_r, rb_r;
  logic [3:0] txc_r, rxc_r;
  logic       txe_r, rxe_r;

  assign tx_cnt = ring_count(tx_w_r, tx_r_r);
  assign rx_cnt = ring_count(rx_w_r, rx_r_r);

  assign stat.action   = act_r;
  assign stat.is_bs    = (data_r == BACKSPACE_BYTE);
  assign stat.tx_empty = (tx_w_r == tx_r_r);
  assign stat.tx_room1 = (tx_cnt != LAST);
  assign stat.tx_room4 = (tx_cnt <= ROOM4);
  assign stat.rx_empty = (rx_w_r == rx_r_r);
  assign stat.rx_full  = (rx_cnt == LAST);

  always_comb begin
    case (cmd.tx_sel)
      SEL_BS:    tx_wr_byte = BACKSPACE_BYTE;
      SEL_SPACE: tx_wr_byte = SPACE_BYTE;
      default:   tx_wr_byte = data_r;
    endcase
  end

  always_comb begin
    tx_w_nxt = cmd.tx_push ? ring_next(tx_w_r) : tx_w_r;
    tx_r_nxt = cmd.tx_pop  ? ring_next(tx_r_r) : tx_r_r;
    rx_w_nxt = cmd.rx_push ? ring_next(rx_w_r) : rx_w_r;
    rx_r_nxt = cmd.rx_pop  ? ring_next(rx_r_r) : rx_r_r;
    tx_cnt_nxt = ring_count(tx_w_nxt, tx_r_nxt);
    rx_cnt_nxt = ring_count(rx_w_nxt, rx_r_nxt);
    tx_cnt_ext = CW'(tx_cnt_nxt);
    rx_cnt_ext = CW'(rx_cnt_nxt);

    tx_irq_nxt = tx_irq_r;
    if (cmd.tx_push && cmd.result) begin
      tx_irq_nxt = 1'b1;
    end else if (cmd.tx_pop && (tx_r_nxt == tx_w_r)) begin
      tx_irq_nxt = 1'b0;
    end

    rx_irq_nxt = rx_irq_r;
    if (cmd.rx_pop) begin
      rx_irq_nxt = 1'b1;
    end else if (cmd.rx_push && (rx_cnt_nxt == LAST)) begin
      rx_irq_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_w_r   <= '0;
      tx_r_r   <= '0;
      rx_w_r   <= '0;
      rx_r_r   <= '0;
      tx_irq_r <= 1'b0;
      rx_irq_r <= 1'b1;
    end else begin
      tx_w_r   <= tx_w_nxt;
      tx_r_r   <= tx_r_nxt;
      rx_w_r   <= rx_w_nxt;
      rx_r_r   <= rx_r_nxt;
      tx_irq_r <= tx_irq_nxt;
      rx_irq_r <= rx_irq_nxt;
    end
  end

  // The read ports are registered and track the read pointers, so the head word is
  // ready in the cycle after any earlier write has landed.
  always_ff @(posedge clk) begin
    if (cmd.tx_push) begin
      tx_mem[tx_w_r] <= tx_wr_byte;
    end
    if (cmd.rx_push) begin
      rx_mem[rx_w_r] <= data_r;
    end
    tx_rd_r <= tx_mem[tx_r_r];
    rx_rd_r <= rx_mem[rx_r_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= act_t'(in_action);
      data_r <= in_data;
    end
    if (cmd.result) begin
      acc_r <= cmd.accepted;
      lv_r  <= cmd.tx_pop;
      lb_r  <= cmd.tx_pop ? tx_rd_r : 8'h00;
      rv_r  <= cmd.rx_pop;
      rb_r  <= cmd.rx_pop ? rx_rd_r : 8'h00;
      txe_r <= tx_irq_nxt;
      rxe_r <= rx_irq_nxt;
      txc_r <= tx_cnt_ext[3:0];
      rxc_r <= rx_cnt_ext[3:0];
    end
  end

  assign out_accepted      = acc_r;
  assign out_line_valid    = lv_r;
  assign out_line_byte     = lb_r;
  assign out_read_valid    = rv_r;
  assign out_read_byte     = rb_r;
  assign out_tx_irq_enable = txe_r;
  assign out_rx_irq_enable = rxe_r;
  assign out_tx_count      = txc_r;
  assign out_rx_count      = rxc_r;

endmodule

FILE: hdl/buq_ctrl.sv
module buq_ctrl import buq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BSW
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    cmd.tx_sel = SEL_DATA;
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd.load  = (state_r == ST_IDLE) && in_valid;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if ((stat.action == ACT_PUT) && stat.is_bs && stat.tx_room4) begin
          // Backspace unit: a word a cycle unless stalled; first here.
          cmd.tx_push = 1'b1;
          cmd.tx_sel  = SEL_BS;
          step_nxt    = 2'd1;
          state_nxt   = ST_BSW;
        end else if (out_free) begin
          cmd.result = 1'b1;
          state_nxt  = ST_IDLE;
          case (stat.action)
            ACT_PUT: begin
              cmd.tx_push  = !stat.is_bs && stat.tx_room1;
              cmd.accepted = !stat.is_bs && stat.tx_room1;
            end
            ACT_GET: begin
              cmd.rx_pop   = !stat.rx_empty;
              cmd.accepted = !stat.rx_empty;
            end
            ACT_LINE: begin
              cmd.tx_pop   = !stat.tx_empty;
              cmd.accepted = !stat.tx_empty;
            end
            default: begin
              cmd.rx_push  = !stat.rx_full;
              cmd.accepted = !stat.rx_full;
            end
          endcase
        end
      end
      ST_BSW: begin
        case (step_r)
          2'd1: begin
            cmd.tx_push = 1'b1;
            cmd.tx_sel  = SEL_SPACE;
            step_nxt    = 2'd2;
          end
          2'd2: begin
            cmd.tx_push = 1'b1;
            cmd.tx_sel  = SEL_BS;
            step_nxt    = 2'd3;
          end
          default: begin
            if (out_free) begin
              cmd.tx_push  = 1'b1;
              cmd.tx_sel   = SEL_DATA;
              cmd.result   = 1'b1;
              cmd.accepted = 1'b1;
              state_nxt    = ST_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/buffered_uart_byte_queues.sv
// Channel   Direction  Payload
// in_ch     sink       action[1:0], data[7:0]
// out_ch    source     accepted, line_valid, line_byte, read_valid, read_byte,
//                      tx_irq_enable, rx_irq_enable, tx_count, rx_count
//
// A word is taken in the idle state and executed in the execute state. A backspace
// put, when the transmit queue has room for four bytes, writes four bytes through
// the single write port of the transmit store; otherwise it is refused.
// The result register lets the next word be taken while a result still waits;
// execution holds only while that register is full and not being drained.
// Synchronous active-low reset empties both queues; the stores need no clearing.
module buffered_uart_byte_queues import buq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  buq_in_if.sink    in_ch,
  buq_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t stat;

  buq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  buq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_action         (in_ch.action),
    .in_data           (in_ch.data),
    .cmd               (cmd),
    .stat              (stat),
    .out_accepted      (out_ch.accepted),
    .out_line_valid    (out_ch.line_valid),
    .out_line_byte     (out_ch.line_byte),
    .out_read_valid    (out_ch.read_valid),
    .out_read_byte     (out_ch.read_byte),
    .out_tx_irq_enable (out_ch.tx_irq_enable),
    .out_rx_irq_enable (out_ch.rx_irq_enable),
    .out_tx_count      (out_ch.tx_count),
    .out_rx_count      (out_ch.rx_count)
  );

endmodule
